@@ hw/rtl/vtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared widths, register indexes, reset values and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

  localparam int FracBitsDef = 16;
  localparam int WordBitsDef = 32;
  localparam int IoBits      = 32;
  localparam int RegBits     = 64;
  localparam int NumRegs     = 8;
  localparam int IdxBits     = 3;
  // Column sums stay well inside this width for any operand pattern.
  localparam int SumBits     = 72;
  localparam int QueueDepth  = 4;
  localparam int QueuePtrBits = 2;

  typedef enum logic [IdxBits-1:0] {
    REG_R0_C01 = 3'd0,
    REG_R0_C23 = 3'd1,
    REG_R1_C01 = 3'd2,
    REG_R1_C23 = 3'd3,
    REG_R2_C01 = 3'd4,
    REG_R2_C23 = 3'd5,
    REG_R3_C01 = 3'd6,
    REG_R3_C23 = 3'd7
  } reg_idx_e;

  localparam logic [RegBits-1:0] RegReset [NumRegs] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  // Request handed from the transform front to the divide back.
  typedef struct packed {
    logic signed [SumBits-1:0] tx;
    logic signed [SumBits-1:0] ty;
    logic signed [SumBits-1:0] tz;
    logic signed [SumBits-1:0] tw;
  } xform_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/vertex_transform_perspective_divide_unit.sv @@
// ----------------------------------------------------------------------------
// Vertex transform with perspective divide
// Row-vector point times 4x4 Q16.16 matrix, then divide of x, y, z by w.
// ----------------------------------------------------------------------------
// One point is accepted every cycle; busy stays low. Each result appears
// for one cycle on done_o. Between the edge that accepts its start and
// done_o lie registered products, registered column sums, the request
// queue, a divide load register, then WORD_BITS+1 quotient stages. The
// receiver cannot stall, so the queue never backs up.
`default_nettype none

module vertex_transform_perspective_divide_unit #(
  parameter int FRAC_BITS = vtpd_pkg::FracBitsDef,
  parameter int WORD_BITS = vtpd_pkg::WordBitsDef
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [vtpd_pkg::IoBits-1:0]       in_x_i,
  input  wire  [vtpd_pkg::IoBits-1:0]       in_y_i,
  input  wire  [vtpd_pkg::IoBits-1:0]       in_z_i,
  input  wire                               cfg_we_i,
  input  wire  [vtpd_pkg::IdxBits-1:0]      cfg_idx_i,
  input  wire  [vtpd_pkg::RegBits-1:0]      cfg_data_i,
  output logic                              done_o,
  output logic [vtpd_pkg::IoBits-1:0]       out_x_o,
  output logic [vtpd_pkg::IoBits-1:0]       out_y_o,
  output logic [vtpd_pkg::IoBits-1:0]       out_z_o,
  output logic                              w_was_zero_o,
  output logic                              saturated_o
);

  logic [vtpd_pkg::RegBits-1:0] mat_q [vtpd_pkg::NumRegs];
  logic                 fr_valid, q_valid, pop;
  vtpd_pkg::xform_req_t fr_req, q_req;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= vtpd_pkg::RegReset;
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  vtpd_front #(.FracBits(FRAC_BITS), .WordBits(WORD_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i(start && !busy),
    .x_i(in_x_i), .y_i(in_y_i), .z_i(in_z_i), .mat_i(mat_q),
    .valid_o(fr_valid), .req_o(fr_req));

  vtpd_queue u_queue (
    .clk_i, .rst_ni, .push_i(fr_valid), .data_i(fr_req),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_req));

  vtpd_back #(.FracBits(FRAC_BITS), .WordBits(WORD_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .req_i(q_req), .pop_o(pop),
    .done_o, .x_o(out_x_o), .y_o(out_y_o), .z_o(out_z_o),
    .wz_o(w_was_zero_o), .sat_o(saturated_o));

endmodule

`default_nettype wire

@@ hw/rtl/vtpd_front.sv @@
// ----------------------------------------------------------------------------
// Vertex transform front
// Accepts points and forms the four homogeneous column sums in two stages:
// registered products, then a registered sum.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_front #(
  parameter int FracBits = vtpd_pkg::FracBitsDef,
  parameter int WordBits = vtpd_pkg::WordBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  input  wire  [vtpd_pkg::IoBits-1:0]  x_i,
  input  wire  [vtpd_pkg::IoBits-1:0]  y_i,
  input  wire  [vtpd_pkg::IoBits-1:0]  z_i,
  input  wire  [vtpd_pkg::RegBits-1:0] mat_i [vtpd_pkg::NumRegs],
  output logic                         valid_o,
  output vtpd_pkg::xform_req_t         req_o
);

  localparam int SB = vtpd_pkg::SumBits;
  localparam int PB = 2 * WordBits;

  logic signed [WordBits-1:0] pt [3];
  logic signed [WordBits-1:0] ent [4][4];
  logic signed [PB-1:0] prod_d [3][4];
  logic signed [PB-1:0] prod_q [3][4];
  logic signed [WordBits-1:0] trans_q [4];
  logic signed [SB-1:0] sum_d [4];
  logic signed [SB-1:0] sum_q [4];
  logic v1_q, v2_q;

  assign pt[0] = x_i[WordBits-1:0];
  assign pt[1] = y_i[WordBits-1:0];
  assign pt[2] = z_i[WordBits-1:0];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = c[0] ? mat_i[2*r + c/2][32 +: WordBits]
                         : mat_i[2*r + c/2][0 +: WordBits];
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 4; c++) begin
        prod_d[i][c] = PB'(pt[i]) * PB'(ent[i][c]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      sum_d[c] = SB'(trans_q[c]);
      for (int i = 0; i < 3; i++) begin
        sum_d[c] = sum_d[c] + SB'(prod_q[i][c] >>> FracBits);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    trans_q <= ent[3];
    sum_q   <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o  = v2_q;
  assign req_o.tx = sum_q[0];
  assign req_o.ty = sum_q[1];
  assign req_o.tz = sum_q[2];
  assign req_o.tw = sum_q[3];

endmodule

`default_nettype wire

@@ hw/rtl/vtpd_queue.sv @@
// ----------------------------------------------------------------------------
// Vertex transform request queue
// Short FIFO between the transform front and the divide back.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  vtpd_pkg::xform_req_t  data_i,
  input  wire                   pop_i,
  output logic                  valid_o,
  output vtpd_pkg::xform_req_t  data_o
);

  localparam int PW = vtpd_pkg::QueuePtrBits;

  vtpd_pkg::xform_req_t mem_q [vtpd_pkg::QueueDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vtpd_divider.sv @@
// ----------------------------------------------------------------------------
// Vertex transform divider
// Pipelined restoring divide of one coordinate by w, one quotient bit per
// stage, with saturation and the zero-w bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_divider #(
  parameter int FracBits = vtpd_pkg::FracBitsDef,
  parameter int WordBits = vtpd_pkg::WordBitsDef
) (
  input  wire                                 clk_i,
  input  wire signed [vtpd_pkg::SumBits-1:0]  a_i,
  input  wire signed [vtpd_pkg::SumBits-1:0]  w_i,
  output logic       [vtpd_pkg::IoBits-1:0]   q_o,
  output logic                                sat_o
);

  localparam int SB = vtpd_pkg::SumBits;
  localparam int IB = vtpd_pkg::IoBits;
  // Quotient bits: WordBits+1 cover every value up to twice the clamp bound.
  localparam int QB = WordBits + 1;
  localparam int NB = SB + FracBits;
  localparam logic signed [SB-1:0] Hi = SB'((64'sd1 <<< (WordBits-1)) - 1);
  localparam logic signed [SB-1:0] Lo = -Hi - 1;

  logic [QB-1:0] num_q  [QB+1];
  logic [SB-1:0] rem_q  [QB+1];
  logic [SB-1:0] wm_q   [QB+1];
  logic [QB-1:0] quo_q  [QB+1];
  logic          big_q  [QB+1];
  logic          neg_q  [QB+1];
  logic          wz_q   [QB+1];
  logic signed [SB-1:0] raw_q [QB+1];

  logic [SB-1:0] am, wm;
  logic [NB-1:0] num;
  logic [NB-1:0] num_hi;
  logic [SB:0]   trial [QB];

  always_comb begin
    am     = a_i[SB-1] ? SB'(-a_i) : SB'(a_i);
    wm     = w_i[SB-1] ? SB'(-w_i) : SB'(w_i);
    num    = {am, FracBits'(0)};
    num_hi = num >> QB;
    for (int s = 0; s < QB; s++) begin
      trial[s] = {rem_q[s], num_q[s][QB-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= num[QB-1:0];
    rem_q[0] <= num_hi[SB-1:0];
    // Any bit above the quotient range means the result saturates.
    big_q[0] <= num_hi >= NB'(wm);
    wm_q[0]  <= wm;
    quo_q[0] <= '0;
    neg_q[0] <= a_i[SB-1] ^ w_i[SB-1];
    wz_q[0]  <= w_i == '0;
    raw_q[0] <= a_i;
    for (int s = 0; s < QB; s++) begin
      if (trial[s] >= {1'b0, wm_q[s]}) begin
        rem_q[s+1] <= SB'(trial[s] - {1'b0, wm_q[s]});
        quo_q[s+1] <= {quo_q[s][QB-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= trial[s][SB-1:0];
        quo_q[s+1] <= {quo_q[s][QB-2:0], 1'b0};
      end
      num_q[s+1] <= num_q[s] << 1;
      big_q[s+1] <= big_q[s];
      wm_q[s+1]  <= wm_q[s];
      neg_q[s+1] <= neg_q[s];
      wz_q[s+1]  <= wz_q[s];
      raw_q[s+1] <= raw_q[s];
    end
  end

  logic signed [SB-1:0] v;
  logic signed [SB-1:0] mag;

  always_comb begin
    mag = SB'(quo_q[QB]);
    if (big_q[QB]) mag = SB'(64'sd1 <<< WordBits);
    if (wz_q[QB]) v = raw_q[QB];
    else          v = neg_q[QB] ? -mag : mag;
    sat_o = 1'b0;
    if (v > Hi) begin
      v = Hi;
      sat_o = 1'b1;
    end else if (v < Lo) begin
      v = Lo;
      sat_o = 1'b1;
    end
    q_o = IB'($signed(v[WordBits-1:0]));
  end

endmodule

`default_nettype wire

@@ hw/rtl/vtpd_back.sv @@
// ----------------------------------------------------------------------------
// Vertex transform back
// Pops requests and runs three coordinate dividers in lockstep.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_back #(
  parameter int FracBits = vtpd_pkg::FracBitsDef,
  parameter int WordBits = vtpd_pkg::WordBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          valid_i,
  input  vtpd_pkg::xform_req_t         req_i,
  output logic                         pop_o,
  output logic                         done_o,
  output logic [vtpd_pkg::IoBits-1:0]  x_o,
  output logic [vtpd_pkg::IoBits-1:0]  y_o,
  output logic [vtpd_pkg::IoBits-1:0]  z_o,
  output logic                         wz_o,
  output logic                         sat_o
);

  localparam int Lat = WordBits + 2;
  localparam int SB  = vtpd_pkg::SumBits;

  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] wz_q;
  logic [2:0] s;

  assign pop_o = valid_i;

  vtpd_divider #(.FracBits(FracBits), .WordBits(WordBits)) u_dx (
    .clk_i, .a_i(req_i.tx), .w_i(req_i.tw), .q_o(x_o), .sat_o(s[0]));
  vtpd_divider #(.FracBits(FracBits), .WordBits(WordBits)) u_dy (
    .clk_i, .a_i(req_i.ty), .w_i(req_i.tw), .q_o(y_o), .sat_o(s[1]));
  vtpd_divider #(.FracBits(FracBits), .WordBits(WordBits)) u_dz (
    .clk_i, .a_i(req_i.tz), .w_i(req_i.tw), .q_o(z_o), .sat_o(s[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    wz_q <= {wz_q[Lat-2:0], req_i.tw == SB'(0)};
  end

  assign done_o = vld_q[Lat-1];
  assign wz_o   = wz_q[Lat-1];
  assign sat_o  = |s;

endmodule

`default_nettype wire

@@ hw/rtl/vtpd_checker.sv @@
// ----------------------------------------------------------------------------
// Vertex transform port checker
// Port-level properties of the transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_checker #(
  parameter int WordBits = vtpd_pkg::WordBitsDef
) (
  input wire clk_i,
  input wire rst_ni,
  input wire start,
  input wire busy,
  input wire done_o,
  input wire w_was_zero_o,
  input wire saturated_o,
  input wire [31:0] out_x_o
);

  localparam int Lat = WordBits + 5;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done_o) else $error("done right after reset");

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o) else $error("result missing");

  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat)) else $error("result without request");

  a_known_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown({out_x_o, w_was_zero_o, saturated_o}))
    else $error("unknown result");

endmodule

bind vertex_transform_perspective_divide_unit vtpd_checker #(.WordBits(WORD_BITS))
  u_vtpd_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .w_was_zero_o, .saturated_o,
  .out_x_o);

`default_nettype wire
